// ----- rtl/fdcd_pkg.sv -----
// Package for the flat and duplicate channel detector.
// Holds sizes, codes, payload structs and the cell control struct.
// No dependencies.
`default_nettype none

package fdcd_pkg;

  // Sizing
  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned NPAIRS      = (CHANNELS * (CHANNELS - 1)) / 2;

  // Configuration port
  localparam int unsigned MASK_BITS     = 8;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Common widths for unsigned compares
  localparam int unsigned CMP_BITS  = (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;
  localparam int unsigned DIFF_BITS = SAMPLE_BITS + 1;
  localparam int unsigned DCMP_BITS = (DIFF_BITS > CFG_DATA_BITS) ? DIFF_BITS : CFG_DATA_BITS;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_EPOCH_END = 2'd1,
    KIND_CLEAR     = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NOISE_MARGIN      = 2'd0,
    CFG_DISCORD_THRESHOLD = 2'd1,
    CFG_INVALID_MASK      = 2'd2
  } cfg_idx_e;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [CMP_BITS-1:0]      cmp_t;
  typedef logic [DCMP_BITS-1:0]     dcmp_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [7:0] flat_mask;
    logic [7:0] dupe_mask;
    logic [3:0] flat_count;
    logic [4:0] dupe_pairs;
    logic       all_distinct;
  } out_t;

  // Control for one discord counter cell
  typedef struct packed {
    logic hit;        // cell addressed by this sample and eligible
    logic disc;       // the compared samples differ by more than the margin
    logic clr_epoch;  // end of epoch: clear count
    logic clr_all;    // new recording: clear count and mark
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/fdcd_sample_bank.sv -----
// Latest sample and seen flag per channel, plus the discord compare of an
// incoming sample against every stored sample.
// Depends on fdcd_pkg.
`default_nettype none

module fdcd_sample_bank (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [fdcd_pkg::CHANNELS-1:0]          we_i,
  input  wire logic signed [fdcd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire fdcd_pkg::cfg_word_t                    margin_i,
  input  wire logic                                   clr_epoch_i,
  input  wire logic                                   clr_all_i,
  output      logic [fdcd_pkg::CHANNELS-1:0]          disc_o,
  output      logic [fdcd_pkg::CHANNELS-1:0]          seen_o
);

  logic signed [fdcd_pkg::SAMPLE_BITS-1:0] latest_q [fdcd_pkg::CHANNELS];
  logic [fdcd_pkg::CHANNELS-1:0]           seen_q, seen_d;

  // Seen flags: cleared at epoch end and on clear, set on write
  always_comb begin
    if (clr_epoch_i || clr_all_i) begin
      seen_d = '0;
    end else begin
      seen_d = seen_q | we_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  assign seen_o = seen_q;

  for (genvar c = 0; c < fdcd_pkg::CHANNELS; c++) begin : g_chan
    logic signed [fdcd_pkg::DIFF_BITS-1:0] diff;
    logic [fdcd_pkg::DIFF_BITS-1:0]        mag;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        latest_q[c] <= '0;
      end else if (clr_all_i) begin
        latest_q[c] <= '0;
      end else if (we_i[c]) begin
        latest_q[c] <= sample_i;
      end
    end

    // |sample - latest| > margin
    always_comb begin
      diff = {sample_i[fdcd_pkg::SAMPLE_BITS-1], sample_i}
           - {latest_q[c][fdcd_pkg::SAMPLE_BITS-1], latest_q[c]};
      mag  = diff[fdcd_pkg::DIFF_BITS-1] ? fdcd_pkg::DIFF_BITS'(-diff)
                                          : fdcd_pkg::DIFF_BITS'(diff);
      disc_o[c] = fdcd_pkg::dcmp_t'(mag) > fdcd_pkg::dcmp_t'(margin_i);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fdcd_discord_cell.sv -----
// One saturating discord counter with its sticky mark; used per channel
// (variability) and per channel pair (divergence).
// Depends on fdcd_pkg.
`default_nettype none

module fdcd_discord_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fdcd_pkg::cell_ctl_t ctl_i,
  input  wire fdcd_pkg::cfg_word_t threshold_i,
  output      logic                mark_d_o
);

  fdcd_pkg::count_t cnt_q, cnt_d, cnt_inc;
  logic             mark_q, mark_d;
  logic             bump;

  // Count only while unmarked; the mark is checked on a discordant sample
  always_comb begin
    bump    = ctl_i.hit && ctl_i.disc && !mark_q;
    cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + fdcd_pkg::count_t'(1);
    cnt_d   = cnt_q;
    mark_d  = mark_q;
    if (ctl_i.clr_all) begin
      cnt_d  = '0;
      mark_d = 1'b0;
    end else if (ctl_i.clr_epoch) begin
      cnt_d  = '0;
    end else if (bump) begin
      cnt_d  = cnt_inc;
      mark_d = fdcd_pkg::cmp_t'(cnt_inc) >= fdcd_pkg::cmp_t'(threshold_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mark_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
    end
  end

  assign mark_d_o = mark_d;

endmodule

`default_nettype wire

// ----- rtl/fdcd_summary.sv -----
// Builds the result from the updated marks and the channel valid mask.
// Depends on fdcd_pkg.
`default_nettype none

module fdcd_summary (
  input  wire logic [fdcd_pkg::CHANNELS-1:0] chan_valid_i,
  input  wire logic [fdcd_pkg::CHANNELS-1:0] var_marks_i,
  input  wire logic [fdcd_pkg::NPAIRS-1:0]   div_marks_i,
  output      fdcd_pkg::out_t                result_o
);

  localparam int unsigned NFLAT_BITS = $clog2(fdcd_pkg::CHANNELS + 1);
  localparam int unsigned NPAIR_BITS = $clog2(fdcd_pkg::NPAIRS + 1);

  logic [fdcd_pkg::CHANNELS-1:0] flat;
  logic [fdcd_pkg::CHANNELS-1:0] dupe;
  logic [fdcd_pkg::NPAIRS-1:0]   live_pair;
  logic [NFLAT_BITS-1:0]         nflat;
  logic [NPAIR_BITS-1:0]         npairs;

  // Live pairs: both ends valid and not divergent
  for (genvar hi = 1; hi < fdcd_pkg::CHANNELS; hi++) begin : g_hi
    for (genvar lo = 0; lo < hi; lo++) begin : g_lo
      localparam int unsigned P = (hi * (hi - 1)) / 2 + lo;
      assign live_pair[P] = chan_valid_i[lo] && chan_valid_i[hi] && !div_marks_i[P];
    end
  end

  // Channel membership in some live pair
  for (genvar c = 0; c < fdcd_pkg::CHANNELS; c++) begin : g_mem
    logic [fdcd_pkg::NPAIRS-1:0] touch;
    for (genvar hi = 1; hi < fdcd_pkg::CHANNELS; hi++) begin : g_hi
      for (genvar lo = 0; lo < hi; lo++) begin : g_lo
        localparam int unsigned P = (hi * (hi - 1)) / 2 + lo;
        assign touch[P] = (lo == c) || (hi == c);
      end
    end
    assign dupe[c] = |(touch & live_pair);
  end

  assign flat   = chan_valid_i & ~var_marks_i;
  assign nflat  = NFLAT_BITS'($countones(flat));
  assign npairs = NPAIR_BITS'($countones(live_pair));

  always_comb begin
    result_o              = '0;
    result_o.flat_mask    = 8'(flat);
    result_o.dupe_mask    = 8'(dupe);
    result_o.flat_count   = 4'(nflat);
    result_o.dupe_pairs   = 5'(npairs);
    result_o.all_distinct = (nflat == '0) && (npairs == '0);
  end

endmodule

`default_nettype wire

// ----- rtl/flat_and_duplicate_channel_detector_core.sv -----
// Flat and duplicate channel detector, top level.
// Depends on fdcd_pkg, fdcd_sample_bank, fdcd_discord_cell, fdcd_summary.
//
// Takes one transaction per clock while the output is not stalled, and
// returns one result per transaction. An accepted transaction is held in
// the input register, and its result is then loaded into the output
// register, where it is offered until taken. An input
// register feeds a single compute stage (one magnitude compare per channel,
// one saturating counter per channel and per channel pair, then the mask
// and count summary) that loads the output register; the output register
// lets a new transaction enter while a finished result waits. Configuration
// writes take effect on the next cycle and should be made while idle.
`default_nettype none

module flat_and_duplicate_channel_detector_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input channel
  input  wire logic                                  in_valid_i,
  output      logic                                  in_ready_o,
  input  wire fdcd_pkg::in_t                         in_item_i,
  // result channel
  output      logic                                  out_valid_o,
  input  wire logic                                  out_ready_i,
  output      fdcd_pkg::out_t                        out_item_o,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [fdcd_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire fdcd_pkg::cfg_word_t                   cfg_wdata_i
);

  // Configuration registers
  fdcd_pkg::cfg_word_t              margin_q, threshold_q;
  logic [fdcd_pkg::MASK_BITS-1:0]   inv_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q    <= '0;
      threshold_q <= fdcd_pkg::cfg_word_t'(1);
      inv_mask_q  <= '0;
    end else if (cfg_we_i) begin
      case (fdcd_pkg::cfg_idx_e'(cfg_idx_i))
        fdcd_pkg::CFG_NOISE_MARGIN:      margin_q    <= cfg_wdata_i;
        fdcd_pkg::CFG_DISCORD_THRESHOLD: threshold_q <= cfg_wdata_i;
        fdcd_pkg::CFG_INVALID_MASK:      inv_mask_q  <= cfg_wdata_i[fdcd_pkg::MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic          s1_valid_q;
  fdcd_pkg::in_t s1_item_q;
  logic          advance;
  logic          out_valid_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // Transaction decode
  logic is_sample, clr_epoch, clr_all;

  always_comb begin
    is_sample = 1'b0;
    clr_epoch = 1'b0;
    clr_all   = 1'b0;
    case (fdcd_pkg::kind_e'(s1_item_q.kind))
      fdcd_pkg::KIND_SAMPLE:    is_sample = advance;
      fdcd_pkg::KIND_EPOCH_END: clr_epoch = advance;
      fdcd_pkg::KIND_CLEAR:     clr_all   = advance;
      default: ;
    endcase
  end

  // Channel validity and sample addressing
  logic [fdcd_pkg::CHANNELS-1:0] chan_valid, ch_hit, disc, seen;

  for (genvar c = 0; c < fdcd_pkg::CHANNELS; c++) begin : g_valid
    if (c < fdcd_pkg::MASK_BITS) begin : g_masked
      assign chan_valid[c] = !inv_mask_q[c];
    end else begin : g_always
      assign chan_valid[c] = 1'b1;
    end
    assign ch_hit[c] = is_sample && (int'(s1_item_q.channel) == c) && chan_valid[c];
  end

  fdcd_sample_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (ch_hit),
    .sample_i    (s1_item_q.sample),
    .margin_i    (margin_q),
    .clr_epoch_i (clr_epoch),
    .clr_all_i   (clr_all),
    .disc_o      (disc),
    .seen_o      (seen)
  );

  // Per-channel variability cells
  logic [fdcd_pkg::CHANNELS-1:0] var_d;

  for (genvar c = 0; c < fdcd_pkg::CHANNELS; c++) begin : g_flat
    fdcd_pkg::cell_ctl_t ctl;
    assign ctl.hit       = ch_hit[c] && seen[c];
    assign ctl.disc      = disc[c];
    assign ctl.clr_epoch = clr_epoch;
    assign ctl.clr_all   = clr_all;

    fdcd_discord_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .threshold_i (threshold_q),
      .mark_d_o    (var_d[c])
    );
  end

  // Per-pair divergence cells; the new sample is on the higher channel
  logic [fdcd_pkg::NPAIRS-1:0] div_d;

  for (genvar hi = 1; hi < fdcd_pkg::CHANNELS; hi++) begin : g_hi
    for (genvar lo = 0; lo < hi; lo++) begin : g_lo
      localparam int unsigned P = (hi * (hi - 1)) / 2 + lo;
      fdcd_pkg::cell_ctl_t ctl;
      assign ctl.hit       = ch_hit[hi] && chan_valid[lo] && seen[lo];
      assign ctl.disc      = disc[lo];
      assign ctl.clr_epoch = clr_epoch;
      assign ctl.clr_all   = clr_all;

      fdcd_discord_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .threshold_i (threshold_q),
        .mark_d_o    (div_d[P])
      );
    end
  end

  // Result summary and output register
  fdcd_pkg::out_t result;

  fdcd_summary u_sum (
    .chan_valid_i (chan_valid),
    .var_marks_i  (var_d),
    .div_marks_i  (div_d),
    .result_o     (result)
  );

  fdcd_pkg::out_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- rtl/fdcd_checker.sv -----
// Port-level checker for the flat and duplicate channel detector, with its
// bind to the top level. Depends on fdcd_pkg.
`default_nettype none

module fdcd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire fdcd_pkg::out_t out_item_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Flat count agrees with the flat mask
  a_flat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.flat_count == 4'($countones(out_item_o.flat_mask))))
    else $error("flat_count does not match flat_mask");

  // A live pair exists exactly when some channel is in the duplicate mask
  a_dupe_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.dupe_pairs == 5'd0) == (out_item_o.dupe_mask == 8'd0)))
    else $error("dupe_pairs and dupe_mask disagree");

  // All-distinct flag follows from the counts
  a_all_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.all_distinct ==
                     ((out_item_o.flat_count == 4'd0) && (out_item_o.dupe_pairs == 5'd0))))
    else $error("all_distinct inconsistent with counts");

endmodule

bind flat_and_duplicate_channel_detector_core fdcd_checker u_fdcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
